// ===== design/jlkv_pkg.sv =====
// Package with the types, constants and helper functions of the JSON line key/value extractor.
package jlkv_pkg;

  localparam int MaxKey     = 16;
  localparam int MaxValue   = 1024;
  localparam int DepthLimit = 64;
  localparam int WinLen     = MaxKey + 3;
  localparam int DepthW     = $clog2(DepthLimit + 1);
  localparam int CntW       = $clog2(MaxValue + 1);
  localparam int KeyLenW    = 5;
  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 2;
  localparam int MaxRes     = 4;
  localparam int FifoDepth  = 8;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);
  localparam int ResCntW    = $clog2(MaxRes + 1);

  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChLBrace    = 8'h7b;
  localparam logic [7:0] ChRBrace    = 8'h7d;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChColon     = 8'h3a;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChN         = 8'h6e;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChL         = 8'h6c;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyLow  = 2'd0,
    CfgKeyHigh = 2'd1,
    CfgKeyLen  = 2'd2,
    CfgRawMode = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PhStart,
    PhScan,
    PhFirst,
    PhValue,
    PhIdle
  } phase_e;

  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindStr  = 2'd1,
    KindNum  = 2'd2,
    KindNull = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_req_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       last_of_value;
  } out_req_t;

  typedef logic [WinLen-1:0][7:0] win_t;
  typedef logic [MaxKey-1:0][7:0] key_t;

  // Letter of "null" expected at the given position.
  function automatic logic [7:0] null_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = ChN;
      2'd1:    c = ChU;
      default: c = ChL;
    endcase
    return c;
  endfunction

  // True when the window, newest byte first, ends with a quote, the key, a quote and a colon.
  function automatic logic needle_match(input win_t w, input key_t key,
                                        input logic [KeyLenW-1:0] len);
    logic hit;
    logic ok;
    hit = 1'b0;
    for (int l = 0; l <= MaxKey; l++) begin
      ok = (w[0] == ChColon) && (w[1] == ChQuote) && (w[l + 2] == ChQuote);
      for (int i = 0; i < l; i++) begin
        ok = ok && (w[1 + l - i] == key[i]);
      end
      if (len == KeyLenW'(l)) begin
        hit = ok;
      end
    end
    return hit;
  endfunction

endpackage

// ===== design/json_line_key_value_extractor.sv =====
// Top level of the JSON line key/value extractor: byte parser and result queue.
//
// The block reads a text stream one byte per request on the input channel
// (in_valid_i, in_stall_o, in_data_i) and sends the bytes of extracted values
// on the output channel (out_valid_o, out_stall_i, out_data_o). The key and
// the raw mode are set through the write port (cfg_we_i, cfg_index_i,
// cfg_data_i) while no request is in flight.
// Each accepted byte is parsed in the cycle it is accepted; its results are
// written into an eight-entry queue; from an empty queue the first one is on
// the output in the next cycle. A value byte is held back until the next
// byte shows whether it is the last one, so it leaves one accepted byte
// later than it arrived. One byte is accepted per cycle unless stalled. A
// byte can cause up to four results, so the input is stalled while fewer
// than four queue entries are free; with an output that is never stalled
// the input is never held back. When the receiver stalls, the queue fills
// and then stalls the input. Reset clears the key registers, the parser
// state and the queue; the next byte starts a new line.
module json_line_key_value_extractor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  jlkv_pkg::in_req_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output jlkv_pkg::out_req_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [jlkv_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [jlkv_pkg::CfgDataW-1:0]   cfg_data_i
);
  import jlkv_pkg::*;

  logic [63:0]         key_low_q, key_high_q;
  logic [KeyLenW-1:0]  key_len_q;
  logic                raw_q;
  logic [KeyLenW-1:0]  key_len_eff;

  win_t                win_q, win_d;
  logic [DepthW-1:0]   depth_q, depth_d;
  phase_e              phase_q, phase_d;
  kind_e               kind_q, kind_d;
  logic [7:0]          held_q, held_d;
  logic                held_vld_q, held_vld_d;
  logic                esc_q, esc_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  out_req_t            res_d [MaxRes];
  logic [ResCntW-1:0]  res_n;
  logic                take_en, fin_en, null_en;
  logic [7:0]          byte_c;
  logic                is_digit, line_end, in_acc;

  out_req_t            fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] fifo_cnt_q;
  logic                pop;

  assign in_stall_o  = (fifo_cnt_q > FifoCntW'(FifoDepth - MaxRes));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  assign key_len_eff = (key_len_q > KeyLenW'(MaxKey)) ? KeyLenW'(MaxKey) : key_len_q;
  assign byte_c      = in_data_i.data_byte;
  assign is_digit    = byte_c inside {[ChZero:ChNine]};
  assign line_end    = (byte_c == ChNewline) || in_data_i.end_of_input;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= '0;
      raw_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgKeyLow:  key_low_q  <= cfg_data_i;
        CfgKeyHigh: key_high_q <= cfg_data_i;
        CfgKeyLen:  key_len_q  <= cfg_data_i[KeyLenW-1:0];
        CfgRawMode: raw_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    win_d      = win_q;
    depth_d    = depth_q;
    phase_d    = phase_q;
    kind_d     = kind_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    for (int k = 0; k < MaxRes; k++) begin
      res_d[k] = '0;
    end
    res_n   = '0;
    take_en = 1'b0;
    fin_en  = 1'b0;
    null_en = 1'b0;
    if (in_acc) begin
      if (byte_c != ChNewline) begin
        case (phase_q)
          PhStart, PhScan: begin
            if (phase_q == PhStart && byte_c != ChLBrace) begin
              phase_d = PhIdle;
            end else begin
              phase_d = PhScan;
              if (byte_c == ChLBrace && depth_q < DepthW'(DepthLimit)) begin
                depth_d = depth_q + 1'b1;
              end else if (byte_c == ChRBrace && depth_q != '0) begin
                depth_d = depth_q - 1'b1;
              end
              win_d = {win_q[WinLen-2:0], byte_c};
              if (depth_d <= DepthW'(1) &&
                  needle_match(win_d, {key_high_q, key_low_q}, key_len_eff)) begin
                phase_d = PhFirst;
              end
            end
          end
          PhFirst: begin
            phase_d = PhValue;
            if (byte_c == ChQuote) begin
              kind_d  = KindStr;
              take_en = raw_q;
            end else if (is_digit) begin
              kind_d  = KindNum;
              take_en = 1'b1;
            end else if (byte_c == ChN) begin
              kind_d = KindNull;
              cnt_d  = CntW'(1);
            end else begin
              phase_d = PhIdle;
            end
          end
          PhValue: begin
            case (kind_q)
              KindStr: begin
                if (esc_q) begin
                  esc_d   = 1'b0;
                  take_en = 1'b1;
                end else if (byte_c == ChBackslash) begin
                  esc_d   = 1'b1;
                  take_en = 1'b1;
                end else if (byte_c == ChQuote) begin
                  take_en = raw_q;
                  fin_en  = 1'b1;
                end else begin
                  take_en = 1'b1;
                end
              end
              KindNum: begin
                if (is_digit) begin
                  take_en = 1'b1;
                end else begin
                  fin_en = 1'b1;
                end
              end
              KindNull: begin
                if (cnt_q >= CntW'(4)) begin
                  null_en = 1'b1;
                  phase_d = PhIdle;
                end else if (byte_c == null_char(cnt_q[1:0])) begin
                  cnt_d = cnt_q + 1'b1;
                end else begin
                  phase_d = PhIdle;
                end
              end
              default: ;
            endcase
          end
          default: ;
        endcase

        if (take_en) begin
          if (held_vld_d) begin
            res_d[res_n[1:0]] = '{value_byte: held_d, last_of_value: 1'b0};
            res_n             = res_n + 1'b1;
            held_vld_d        = 1'b0;
          end
          cnt_d = cnt_d + 1'b1;
          if (cnt_d >= CntW'(MaxValue)) begin
            res_d[res_n[1:0]] = '{value_byte: byte_c, last_of_value: 1'b1};
            res_n             = res_n + 1'b1;
            phase_d           = PhIdle;
          end else begin
            held_d     = byte_c;
            held_vld_d = 1'b1;
          end
        end
        if (fin_en) begin
          if (held_vld_d) begin
            res_d[res_n[1:0]] = '{value_byte: held_d, last_of_value: 1'b1};
            res_n             = res_n + 1'b1;
          end
          held_vld_d = 1'b0;
          phase_d    = PhIdle;
        end
        if (null_en) begin
          res_d[0] = '{value_byte: ChN, last_of_value: 1'b0};
          res_d[1] = '{value_byte: ChU, last_of_value: 1'b0};
          res_d[2] = '{value_byte: ChL, last_of_value: 1'b0};
          res_d[3] = '{value_byte: ChL, last_of_value: 1'b1};
          res_n    = ResCntW'(MaxRes);
        end
      end

      if (line_end) begin
        if (phase_d == PhValue && kind_d != KindNull && held_vld_d) begin
          res_d[res_n[1:0]] = '{value_byte: held_d, last_of_value: 1'b1};
          res_n             = res_n + 1'b1;
        end
        win_d      = '0;
        depth_d    = '0;
        phase_d    = PhStart;
        kind_d     = KindNone;
        held_d     = '0;
        held_vld_d = 1'b0;
        esc_d      = 1'b0;
        cnt_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      depth_q    <= '0;
      phase_q    <= PhStart;
      kind_q     <= KindNone;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      esc_q      <= 1'b0;
      cnt_q      <= '0;
    end else begin
      win_q      <= win_d;
      depth_q    <= depth_d;
      phase_q    <= phase_d;
      kind_q     <= kind_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      esc_q      <= esc_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (ResCntW'(k) < res_n) begin
        fifo_q[wr_ptr_q + FifoPtrW'(k)] <= res_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + FifoPtrW'(res_n);
      rd_ptr_q   <= rd_ptr_q + FifoPtrW'(pop);
      fifo_cnt_q <= fifo_cnt_q + FifoCntW'(res_n) - FifoCntW'(pop);
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= FifoCntW'(FifoDepth))
    else $error("Result queue holds more entries than it has.");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(DepthLimit))
    else $error("Brace depth went past its limit.");

  a_held_in_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_vld_q |-> (phase_q == PhValue && (kind_q == KindStr || kind_q == KindNum)))
    else $error("A held byte exists outside a string or number value.");

  a_escape_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> kind_q == KindStr)
    else $error("Escape pending outside a string value.");

  a_no_push_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> fifo_cnt_q <= $past(fifo_cnt_q))
    else $error("Results were queued without an accepted request.");

endmodule

// ===== dv/tb.sv =====
// Testbench for the JSON line key/value extractor: random lines checked against a byte-level predictor.
`timescale 1ns / 1ps

module tb;
  import jlkv_pkg::*;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned LongHold     = 400;

  typedef struct {
    in_req_t req;
    bit      drain;
  } pend_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_req_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_req_t            out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  json_line_key_value_extractor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Extractor state as the predictor sees it.
  logic [7:0]         win [WinLen];
  int unsigned        depth_now;
  phase_e             phase_now;
  kind_e              kind_now;
  logic [7:0]         held_b;
  bit                 held_v;
  bit                 esc_now;
  int unsigned        taken;
  logic [63:0]        key_lo;
  logic [63:0]        key_hi;
  logic [KeyLenW-1:0] key_len;
  bit                 raw_on;

  out_req_t    value_q[$];
  pend_t       byte_q[$];
  int unsigned emitted;
  bit          drain_next;

  int unsigned pred_cnt     = 0;
  int unsigned got_cnt      = 0;
  int unsigned accepted_cnt = 0;
  int unsigned stall_seen   = 0;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned phase_cnt    = 0;

  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  bit          held_long  = 1'b0;
  bit          hold_go    = 1'b0;
  bit          recv_calm  = 1'b0;

  function automatic int unsigned key_used();
    return (key_len > MaxKey) ? MaxKey : key_len;
  endfunction

  function automatic logic [7:0] key_at(int unsigned i);
    return (i < 8) ? key_lo[8*i +: 8] : key_hi[8*(i-8) +: 8];
  endfunction

  function automatic void put_value(logic [7:0] b, bit last);
    out_req_t r;
    r.value_byte    = b;
    r.last_of_value = last;
    value_q.push_back(r);
    emitted++;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    if (held_v) begin
      put_value(held_b, 1'b0);
      held_v = 1'b0;
    end
    taken++;
    if (taken >= MaxValue) begin
      put_value(b, 1'b1);
      phase_now = PhIdle;
    end else begin
      held_b = b;
      held_v = 1'b1;
    end
  endfunction

  function automatic void close_value();
    if (held_v) put_value(held_b, 1'b1);
    held_v    = 1'b0;
    phase_now = PhIdle;
  endfunction

  function automatic void restart_line();
    foreach (win[i]) win[i] = '0;
    depth_now = 0;
    phase_now = PhStart;
    kind_now  = KindNone;
    held_b    = '0;
    held_v    = 1'b0;
    esc_now   = 1'b0;
    taken     = 0;
  endfunction

  function automatic bit needle_here();
    int unsigned n;
    bit ok;
    n  = key_used();
    ok = (win[0] == ChColon) && (win[1] == ChQuote) && (win[n + 2] == ChQuote);
    for (int unsigned i = 0; i < n; i++) begin
      if (win[1 + n - i] != key_at(i)) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    bit digit;
    logic [7:0] null_letters [4];
    digit        = (b >= ChZero) && (b <= ChNine);
    null_letters = '{ChN, ChU, ChL, ChL};
    case (phase_now)
      PhStart, PhScan: begin
        if (phase_now == PhStart && b != ChLBrace) begin
          phase_now = PhIdle;
        end else begin
          phase_now = PhScan;
          if (b == ChLBrace && depth_now < DepthLimit) depth_now++;
          else if (b == ChRBrace && depth_now > 0) depth_now--;
          for (int i = WinLen - 1; i > 0; i--) win[i] = win[i-1];
          win[0] = b;
          if (depth_now <= 1 && needle_here()) phase_now = PhFirst;
        end
      end
      PhFirst: begin
        phase_now = PhValue;
        if (b == ChQuote) begin
          kind_now = KindStr;
          if (raw_on) take_byte(b);
        end else if (digit) begin
          kind_now = KindNum;
          take_byte(b);
        end else if (b == ChN) begin
          kind_now = KindNull;
          taken    = 1;
        end else begin
          phase_now = PhIdle;
        end
      end
      PhValue: begin
        if (kind_now == KindStr) begin
          if (esc_now) begin
            esc_now = 1'b0;
            take_byte(b);
          end else if (b == ChBackslash) begin
            esc_now = 1'b1;
            take_byte(b);
          end else if (b == ChQuote) begin
            if (raw_on) take_byte(b);
            close_value();
          end else begin
            take_byte(b);
          end
        end else if (kind_now == KindNum) begin
          if (digit) take_byte(b);
          else close_value();
        end else begin
          if (taken >= 4) begin
            put_value(ChN, 1'b0);
            put_value(ChU, 1'b0);
            put_value(ChL, 1'b0);
            put_value(ChL, 1'b1);
            phase_now = PhIdle;
          end else if (b == null_letters[taken]) begin
            taken++;
          end else begin
            phase_now = PhIdle;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void step_byte(in_req_t r);
    emitted = 0;
    if (r.data_byte != ChNewline) scan_byte(r.data_byte);
    if (r.data_byte == ChNewline || r.end_of_input) begin
      if (phase_now == PhValue && kind_now != KindNull) close_value();
      restart_line();
    end
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ChNewline || b == ChQuote || b == ChBackslash);
    return b;
  endfunction

  function automatic logic [63:0] key_word();
    logic [63:0] w;
    logic [7:0] c;
    for (int i = 0; i < 8; i++) begin
      do c = 8'($urandom_range(33, 126));
      while (c == ChQuote || c == ChLBrace || c == ChRBrace);
      w[8*i +: 8] = c;
    end
    return w;
  endfunction

  // Request driver.
  always @(posedge clk_i) begin : drive
    pend_t nx;
    bit nv;
    if (rst_ni) begin
      nv = in_valid_i;
      if (in_valid_i && in_stall_o) stall_seen <= stall_seen + 1;
      if (in_valid_i && !in_stall_o) begin
        step_byte(in_data_i);
        pred_cnt     <= pred_cnt + emitted;
        accepted_cnt <= accepted_cnt + 1;
        nv           = 1'b0;
        send_gap     = send_calm ? 0 : gap_len();
      end
      if (!nv) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (byte_q.size() != 0 && (!byte_q[0].drain || value_q.size() == 0)) begin
          nx        = byte_q.pop_front();
          in_data_i <= nx.req;
          nv        = 1'b1;
        end
      end
      in_valid_i <= nv;
      if ($urandom_range(0, 127) == 0) send_calm = !send_calm;
    end
  end

  // Output stall generator, with one long hold-off while a value-heavy line is offered.
  always @(posedge clk_i) begin : recv_stall
    bit s;
    if (rst_ni) begin
      s = 1'b0;
      if (hold_left != 0) begin
        hold_left--;
        s = 1'b1;
      end else if (!held_long && hold_go) begin
        held_long = 1'b1;
        hold_left = LongHold - 1;
        s         = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        s = 1'b1;
      end else if (!recv_calm) begin
        stall_left = gap_len();
        if (stall_left != 0) begin
          stall_left--;
          s = 1'b1;
        end
      end
      if ($urandom_range(0, 127) == 0) recv_calm = !recv_calm;
      out_stall_i <= s;
    end
  end

  // Output checker.
  always @(posedge clk_i) begin : watch
    out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_cnt <= got_cnt + 1;
      if (value_q.size() == 0) begin
        $display("%0t: unexpected value byte %h last %b", $time,
                 out_data_o.value_byte, out_data_o.last_of_value);
        err_cnt++;
      end else begin
        want = value_q.pop_front();
        if (out_data_o.value_byte != want.value_byte) begin
          $display("%0t: value_byte expected %h actual %h", $time,
                   want.value_byte, out_data_o.value_byte);
          err_cnt++;
        end
        if (out_data_o.last_of_value != want.last_of_value) begin
          $display("%0t: last_of_value expected %b actual %b", $time,
                   want.last_of_value, out_data_o.last_of_value);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(logic [7:0] b, bit e);
    pend_t p;
    p.req.data_byte    = b;
    p.req.end_of_input = e;
    p.drain            = drain_next;
    drain_next         = 1'b0;
    byte_q.push_back(p);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  task automatic send_key();
    for (int unsigned i = 0; i < key_used(); i++) send(key_at(i), 1'b0);
  endtask

  task automatic send_needle();
    send(ChQuote, 1'b0);
    send_key();
    send(ChQuote, 1'b0);
    send(ChColon, 1'b0);
  endtask

  task automatic end_line();
    int unsigned r;
    pend_t p;
    r = $urandom_range(0, 19);
    if (r == 19) begin
      p = byte_q.pop_back();
      p.req.end_of_input = 1'b1;
      byte_q.push_back(p);
    end else begin
      send(ChNewline, r >= 17);
    end
  endtask

  task automatic send_value(output bit real_value);
    int unsigned pick;
    int unsigned n;
    string odd_start;
    odd_start  = " tf-[";
    real_value = 1'b1;
    pick       = $urandom_range(0, 99);
    if (pick < 40) begin
      send(ChQuote, 1'b0);
      n = $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          send(ChBackslash, 1'b0);
          send($urandom_range(0, 1) ? ChQuote : text_byte(), 1'b0);
        end else begin
          send(text_byte(), 1'b0);
        end
      end
      if ($urandom_range(0, 9) != 0) send(ChQuote, 1'b0);
    end else if (pick < 70) begin
      n = $urandom_range(1, 6);
      repeat (n) send(8'($urandom_range(ChZero, ChNine)), 1'b0);
    end else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0, 1:    send_text("null");
        2:       send_text("nulx");
        default: send_text("nu");
      endcase
    end else begin
      send(odd_start[$urandom_range(0, 4)], 1'b0);
      real_value = 1'b0;
    end
  endtask

  task automatic object_line(output bit has_value);
    int unsigned n;
    bit v;
    has_value = 1'b0;
    send(ChLBrace, 1'b0);
    n = $urandom_range(0, 2);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: send_text("\"q\":1,");
        1: begin
          send_text("\"a\":{");
          send_needle();
          send_text("5},");
        end
        2: send_text("\"s\":\"}\",");
        3: send_text("}}");
        4: send_text("\"s\":\"{\",");
        default: begin
          send(ChQuote, 1'b0);
          send_key();
          send_text("~\":3,");
        end
      endcase
    end
    if ($urandom_range(0, 99) < 85) begin
      send_needle();
      send_value(v);
      has_value = v;
    end
    case ($urandom_range(0, 3))
      0: send_text(",\"z\":2");
      1: begin
        send(8'h2c, 1'b0);
        send_needle();
        send_text("7");
      end
      default: ;
    endcase
    send(ChRBrace, 1'b0);
    end_line();
  endtask

  task automatic noise_line();
    int unsigned n;
    n = $urandom_range(1, 12);
    repeat (n) send(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    end_line();
  endtask

  task automatic stray_line();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == ChLBrace || b == ChNewline);
    send(b, 1'b0);
    send_needle();
    send_text("1}");
    end_line();
  endtask

  task automatic deep_line();
    repeat (DepthLimit + 2) send(ChLBrace, 1'b0);
    repeat (DepthLimit - 1) send(ChRBrace, 1'b0);
    send_needle();
    send_text("42}");
    send(ChNewline, 1'b0);
  endtask

  // A string value long enough to fill the result queue while the receiver holds off.
  task automatic fill_line();
    send(ChLBrace, 1'b0);
    send_needle();
    send(ChQuote, 1'b0);
    repeat (10) send(text_byte(), 1'b0);
    send(ChQuote, 1'b0);
    send(ChRBrace, 1'b0);
    send(ChNewline, 1'b0);
  endtask

  task automatic random_lines(int unsigned min_bytes, int unsigned min_values);
    int unsigned start;
    int unsigned values;
    int unsigned pick;
    bit v;
    start  = byte_q.size();
    values = 0;
    while (byte_q.size() - start < min_bytes || values < min_values) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        noise_line();
      end else if (pick < 14) begin
        stray_line();
      end else begin
        object_line(v);
        values += v;
      end
    end
    send(ChNewline, 1'b0);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || in_valid_i || pred_cnt != got_cnt);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgKeyLow:  key_lo = val;
      CfgKeyHigh: key_hi = val;
      CfgKeyLen:  key_len = val[KeyLenW-1:0];
      default:    raw_on = val[0];
    endcase
  endtask

  task automatic set_key(logic [63:0] lo, logic [63:0] hi, logic [4:0] len, bit raw);
    write_reg(CfgKeyLow, lo);
    write_reg(CfgKeyHigh, hi);
    write_reg(CfgKeyLen, {$urandom, 27'($urandom), len});
    write_reg(CfgRawMode, {$urandom, 31'($urandom), raw});
    phase_cnt++;
  endtask

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    key_lo     = '0;
    key_hi     = '0;
    key_len    = '0;
    raw_on     = 1'b0;
    drain_next = 1'b0;
    restart_line();
    phase_cnt = 1;

    // Empty key after reset: number cut by end of input, null, escaped quote and extreme bytes.
    send_text("{\"\":");
    send(8'h39, 1'b1);
    send_text("{\"\":null}\n");
    send_text("{\"\":\"\\\"");
    send(8'hff, 1'b0);
    send(8'h00, 1'b0);
    send(ChQuote, 1'b0);
    send(ChNewline, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    set_key({32'($urandom), 16'($urandom), 16'h6469}, {$urandom, $urandom}, 5'd2, 1'b1);
    hold_go = 1'b1;
    fill_line();
    random_lines(20, 1);
    wait_idle();

    lo = key_word();
    hi = key_word();
    set_key(lo, hi, 5'd31, 1'b0);
    random_lines(30, 1);
    wait_idle();

    set_key('0, '0, 5'd0, 1'b0);
    random_lines(10, 1);
    drain_next = 1'b1;
    deep_line();
    wait_idle();

    lo = key_word();
    set_key({lo[63:16], 16'h7b6b}, key_word(), 5'd2, 1'($urandom_range(0, 1)));
    random_lines(20, 1);
    wait_idle();

    if (value_q.size() != 0) begin
      $display("%0t: %0d expected value bytes never arrived", $time, value_q.size());
      err_cnt++;
    end
    $display("tb: %0d bytes over %0d key settings, %0d value bytes compared",
             accepted_cnt, phase_cnt, got_cnt);
    $display("tb: long output hold-off %0s, input held back on %0d cycles",
             held_long ? "done" : "not reached", stall_seen);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/jlkv_pkg.sv
design/json_line_key_value_extractor.sv
dv/tb.sv
